// File: design/recency_ordered_lru_table_assert.svh
// Assertion macros shared by the recency table RTL.
// Each macro expects clk and rst_n in scope.
`ifndef RECENCY_ORDERED_LRU_TABLE_ASSERT_SVH
`define RECENCY_ORDERED_LRU_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define LRU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LRU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRU_ASSERT_IMP(label, ante, cons, msg)
`define LRU_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: design/lru_pkg.sv
`default_nettype none
package lru_pkg;
    localparam int KEY_W  = 56;
    localparam int TIME_W = 32;

    localparam logic [2:0] OP_ENSURE = 3'd0;
    localparam logic [2:0] OP_TOUCH  = 3'd1;
    localparam logic [2:0] OP_DROP   = 3'd2;
    localparam logic [2:0] OP_GET    = 3'd3;
    localparam logic [2:0] OP_EVICT  = 3'd4;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_EVICTED  = 2'd2;
    localparam logic [1:0] ST_MISS     = 2'd3;

    typedef struct packed {
        logic clr;    // clear rank counter
        logic cnt_en; // count against broadcast time
        logic shift;  // take entry from upper neighbour
        logic load;   // take broadcast load data
    } cell_ctl_t;
endpackage
`default_nettype wire

// File: design/recency_ordered_lru_table.sv
// The filled entries are swept in S_SCAN, one entry per cycle; a get by a
//   valid rank then walks them again in S_PICK up to that rank's entry, and
//   S_FIN registers done; an empty table goes straight to S_FIN.
//   One transaction in flight; the next may start in the cycle done is shown.
// Reset clears the fill count and controller; entry contents are not reset.
// The receiver cannot stall: done pulses for one cycle with the result.
`default_nettype none
`include "recency_ordered_lru_table_assert.svh"
module recency_ordered_lru_table #(
    parameter int ENTRIES = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  op,
    input  wire  [7:0]  key_type,
    input  wire  [47:0] key_id,
    input  wire  [31:0] time_req,
    input  wire  [7:0]  rank,
    output logic        done,
    output logic [1:0]  status,
    output logic [4:0]  slot,
    output logic [7:0]  out_key_type,
    output logic [47:0] out_key_id,
    output logic [31:0] out_time,
    output logic [5:0]  occupancy
);
    import lru_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PICK, S_FIN} state_t;

    state_t             state_reg;
    logic [FW-1:0]      fill_reg;
    logic [IW-1:0]      k_reg;
    logic [2:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [TIME_W-1:0]  treq_reg;
    logic [7:0]         rank_reg;

    // scan results
    logic               found_reg;
    logic [IW-1:0]      fidx_reg;
    logic [TIME_W-1:0]  ftime_reg;
    logic [TIME_W-1:0]  max_reg;
    logic [IW-1:0]      midx_reg;
    logic [KEY_W-1:0]   mkey_reg;
    logic [TIME_W-1:0]  mtime_reg;
    logic [IW-1:0]      pidx_reg;
    logic [KEY_W-1:0]   pkey_reg;
    logic [TIME_W-1:0]  ptime_reg;

    // result registers
    logic               done_reg;
    logic [1:0]         status_reg;
    logic [4:0]         slot_reg;
    logic [KEY_W-1:0]   okey_reg;
    logic [TIME_W-1:0]  otime_reg;

    // cell chain
    logic [KEY_W-1:0]   c_key  [ENTRIES];
    logic [TIME_W-1:0]  c_time [ENTRIES];
    logic [IW-1:0]      c_cnt  [ENTRIES];
    cell_ctl_t          c_ctl  [ENTRIES];

    logic [KEY_W-1:0]   rd_key;
    logic [TIME_W-1:0]  rd_time;
    logic [IW-1:0]      rd_cnt;
    logic               last_k;
    logic               rank_ok;

    // finishing-cycle decisions
    logic               rm_en;
    logic [IW-1:0]      rm_pos;
    logic               ld_en;
    logic [IW-1:0]      ld_pos;
    logic [TIME_W-1:0]  ld_time;
    logic [FW-1:0]      fill_fin;
    logic [1:0]         r_status;
    logic [IW-1:0]      r_slot;
    logic [KEY_W-1:0]   r_key;
    logic [TIME_W-1:0]  r_time;
    logic [TIME_W-1:0]  nt;
    logic [TIME_W-1:0]  touched;

    assign busy    = (state_reg != S_IDLE);
    assign rd_key  = c_key[k_reg];
    assign rd_time = c_time[k_reg];
    assign rd_cnt  = c_cnt[k_reg];
    assign last_k  = ({1'b0, k_reg} == (IW + 1)'(fill_reg - 1'b1));
    assign rank_ok = ({{FW{1'b0}}, rank_reg} < {8'd0, fill_reg});

    // touch: newest time, never lowering the stored one
    assign nt      = (treq_reg > max_reg) ? treq_reg : max_reg + 1'b1;
    assign touched = (nt > ftime_reg) ? nt : ftime_reg;

    always_comb
    begin
        rm_en    = 1'b0;
        rm_pos   = '0;
        ld_en    = 1'b0;
        ld_pos   = '0;
        ld_time  = '0;
        fill_fin = fill_reg;
        r_status = ST_MISS;
        r_slot   = '0;
        r_key    = '0;
        r_time   = '0;
        unique case (op_reg)
            OP_ENSURE:
            begin
                if (found_reg)
                begin
                    r_status = ST_DONE;
                    r_slot   = fidx_reg;
                    r_key    = key_reg;
                    r_time   = ftime_reg;
                end
                else if (fill_reg == FW'(ENTRIES))
                begin
                    // evict least recent, rest shift down, append at the top
                    rm_en    = 1'b1;
                    rm_pos   = midx_reg;
                    ld_en    = 1'b1;
                    ld_pos   = IW'(ENTRIES - 1);
                    r_status = ST_EVICTED;
                    r_slot   = IW'(ENTRIES - 1);
                    r_key    = mkey_reg;
                end
                else
                begin
                    ld_en    = 1'b1;
                    ld_pos   = IW'(fill_reg);
                    fill_fin = fill_reg + 1'b1;
                    r_status = ST_INSERTED;
                    r_slot   = IW'(fill_reg);
                    r_key    = key_reg;
                end
            end
            OP_TOUCH:
            begin
                if (found_reg)
                begin
                    ld_en    = 1'b1;
                    ld_pos   = fidx_reg;
                    ld_time  = touched;
                    r_status = ST_DONE;
                    r_slot   = fidx_reg;
                    r_key    = key_reg;
                    r_time   = touched;
                end
            end
            OP_DROP:
            begin
                if (found_reg)
                begin
                    rm_en    = 1'b1;
                    rm_pos   = fidx_reg;
                    fill_fin = fill_reg - 1'b1;
                    r_status = ST_DONE;
                    r_slot   = fidx_reg;
                    r_key    = key_reg;
                    r_time   = ftime_reg;
                end
            end
            OP_GET:
            begin
                if (rank_ok)
                begin
                    r_status = ST_DONE;
                    r_slot   = pidx_reg;
                    r_key    = pkey_reg;
                    r_time   = ptime_reg;
                end
            end
            OP_EVICT:
            begin
                if (fill_reg != '0)
                begin
                    rm_en    = 1'b1;
                    rm_pos   = midx_reg;
                    fill_fin = fill_reg - 1'b1;
                    r_status = ST_DONE;
                    r_slot   = midx_reg;
                    r_key    = mkey_reg;
                    r_time   = mtime_reg;
                end
            end
            default:
            begin
                r_status = ST_MISS;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            logic [KEY_W-1:0]  nb_key;
            logic [TIME_W-1:0] nb_time;
            logic              valid;

            if (gi < ENTRIES - 1)
            begin : g_nb
                assign nb_key  = c_key[gi + 1];
                assign nb_time = c_time[gi + 1];
            end
            else
            begin : g_top
                assign nb_key  = c_key[gi];
                assign nb_time = c_time[gi];
            end

            assign valid = ({1'b0, IW'(gi)} < (IW + 1)'(fill_reg));

            always_comb
            begin
                c_ctl[gi].clr    = (state_reg == S_IDLE) && start;
                c_ctl[gi].cnt_en = (state_reg == S_SCAN);
                c_ctl[gi].shift  = (state_reg == S_FIN) && rm_en &&
                                   (IW'(gi) >= rm_pos) && (gi < ENTRIES - 1);
                c_ctl[gi].load   = (state_reg == S_FIN) && ld_en && (ld_pos == IW'(gi));
            end

            lru_cell #(
                .IW  (IW),
                .IDX (gi)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (c_ctl[gi]),
                .valid   (valid),
                .bc_time (rd_time),
                .bc_idx  (k_reg),
                .nb_key  (nb_key),
                .nb_time (nb_time),
                .ld_key  (key_reg),
                .ld_time (ld_time),
                .key     (c_key[gi]),
                .tstamp  (c_time[gi]),
                .cnt     (c_cnt[gi])
            );
        end
    endgenerate

    // working registers of the sweep
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg    <= op;
            key_reg   <= {key_type, key_id};
            treq_reg  <= time_req;
            rank_reg  <= rank;
            found_reg <= 1'b0;
            max_reg   <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            if (!found_reg && rd_key == key_reg)
            begin
                found_reg <= 1'b1;
                fidx_reg  <= k_reg;
                ftime_reg <= rd_time;
            end
            if (rd_time > max_reg)
                max_reg <= rd_time;
            // strict less: first index wins ties
            if (k_reg == '0 || rd_time < mtime_reg)
            begin
                midx_reg  <= k_reg;
                mkey_reg  <= rd_key;
                mtime_reg <= rd_time;
            end
        end
        else if (state_reg == S_PICK)
        begin
            if ({8'd0, rd_cnt} == {{IW{1'b0}}, rank_reg})
            begin
                pidx_reg  <= k_reg;
                pkey_reg  <= rd_key;
                ptime_reg <= rd_time;
            end
        end
        if (state_reg == S_FIN)
        begin
            status_reg <= r_status;
            slot_reg   <= 5'(r_slot);
            okey_reg   <= r_key;
            otime_reg  <= r_time;
        end
    end

    // controller
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    k_reg <= '0;
                    if (start)
                        state_reg <= (fill_reg == '0) ? S_FIN : S_SCAN;
                end
                S_SCAN:
                begin
                    if (last_k)
                    begin
                        k_reg     <= '0;
                        state_reg <= (op_reg == OP_GET && rank_ok) ? S_PICK : S_FIN;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_PICK:
                begin
                    if ({8'd0, rd_cnt} == {{IW{1'b0}}, rank_reg} || last_k)
                        state_reg <= S_FIN;
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_FIN:
                begin
                    fill_reg  <= fill_fin;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign out_key_type = okey_reg[KEY_W-1:48];
    assign out_key_id   = okey_reg[47:0];
    assign out_time     = otime_reg;
    assign occupancy    = 6'(fill_reg);

    `LRU_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= FW'(ENTRIES), "fill count overflow")
    `LRU_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted transaction not busy")
    `LRU_ASSERT_IMP(a_done_prev, done, $past(state_reg == S_FIN), "done without finish")
    `LRU_ASSERT_IMP(a_evict_full, done && status == ST_EVICTED,
                    fill_reg == FW'(ENTRIES), "eviction insert on table not full")
endmodule
`default_nettype wire

// File: design/lru_cell.sv
`default_nettype none
module lru_cell #(
    parameter int IW  = 5,
    parameter int IDX = 0
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  lru_pkg::cell_ctl_t           ctl,
    input  wire                          valid,
    input  wire [lru_pkg::TIME_W-1:0]    bc_time,
    input  wire [IW-1:0]                 bc_idx,
    input  wire [lru_pkg::KEY_W-1:0]     nb_key,
    input  wire [lru_pkg::TIME_W-1:0]    nb_time,
    input  wire [lru_pkg::KEY_W-1:0]     ld_key,
    input  wire [lru_pkg::TIME_W-1:0]    ld_time,
    output logic [lru_pkg::KEY_W-1:0]    key,
    output logic [lru_pkg::TIME_W-1:0]   tstamp,
    output logic [IW-1:0]                cnt
);
    import lru_pkg::*;

    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] time_reg;
    logic [IW-1:0]     cnt_reg;
    logic              newer;

    // broadcast entry ranks above this one: later index wins ties
    assign newer = (bc_time > time_reg) ||
                   ((bc_time == time_reg) && (bc_idx > IW'(IDX)));

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg  <= ld_key;
            time_reg <= ld_time;
        end
        else if (ctl.shift)
        begin
            key_reg  <= nb_key;
            time_reg <= nb_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (ctl.clr)
            cnt_reg <= '0;
        else if (ctl.cnt_en && valid && newer)
            cnt_reg <= cnt_reg + 1'b1;
    end

    assign key    = key_reg;
    assign tstamp = time_reg;
    assign cnt    = cnt_reg;
endmodule
`default_nettype wire
